// ===== hw/rtl/mavg_pkg.sv =====
// ----------------------------------------------------------------------------
// mavg_pkg: shared types for the moving average block
// Status that the divider unit reports to the back end.
// ----------------------------------------------------------------------------
package mavg_pkg;

  // Divider status: busy while iterating, done holds until the next start
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/moving_average_window.sv =====
// ----------------------------------------------------------------------------
// moving_average_window: boxcar moving average over the last WINDOW samples
// Front FIFO, ring and running sum back end with an iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   Sample words enter on the s_axis channel; each yields one result word on
//   the m_axis channel holding the truncated mean of the last min(n, WINDOW)
//   samples and the count used. Words are taken when tvalid and tready are
//   both high.
//   A two-word input FIFO parts the input from the back end, so input words
//   are still taken while a result waits at the output.
//   The back end handles one word at a time: ring read, sum update, then the
//   radix-2 divider producing one quotient bit per cycle, then the output
//   register load.
//   Reset clears the running sum, write index, fill count and FIFO; the ring
//   needs no clearing, as an old entry enters the sum only after it has been written.
//   When the receiver stalls, the result word holds, the back end waits at
//   its divider, and the input FIFO fills and then drops s_axis_tready.
// ----------------------------------------------------------------------------
module moving_average_window import mavg_pkg::*; #(
  parameter int WINDOW      = 128,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            s_axis_tvalid,
  output logic                                            s_axis_tready,
  // tdata: sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]                s_axis_tdata,
  output logic                                            m_axis_tvalid,
  input  logic                                            m_axis_tready,
  // tdata: average, samples_used
  output logic [((SAMPLE_BITS+$clog2(WINDOW+1)+7)/8)*8-1:0] m_axis_tdata
);

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int IN_DW  = ((SAMPLE_BITS + 7) / 8) * 8;

  logic                   q_valid, q_ready;
  logic [SAMPLE_BITS-1:0] q_sample;
  logic [SAMPLE_BITS-1:0] avg;
  logic [CNT_W-1:0]       used;

  mavg_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .IN_DW       (IN_DW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_sample_o (q_sample)
  );

  mavg_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_sample_i  (q_sample),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_avg_o   (avg),
    .out_used_o  (used)
  );

  // pack result word, zero padding on top
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[SAMPLE_BITS-1:0] = avg;
    m_axis_tdata[SAMPLE_BITS+CNT_W-1:SAMPLE_BITS] = used;
  end

endmodule

// ===== hw/rtl/mavg_front.sv =====
// ----------------------------------------------------------------------------
// mavg_front: input side of the moving average block
// Takes sample words off the input stream, keeps the live sample bits and
// queues them in a short FIFO so that the back end can stall on its own.
// ----------------------------------------------------------------------------
module mavg_front import mavg_pkg::*; #(
  parameter int SAMPLE_BITS = 10,
  parameter int IN_DW       = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [IN_DW-1:0]       in_data_i,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output logic [SAMPLE_BITS-1:0] q_sample_o
);

  localparam int unsigned QDEPTH = 2;

  logic [SAMPLE_BITS-1:0] mem_q [QDEPTH];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             cnt_q, cnt_d;
  logic                   push, pop;

  assign in_ready_o = (cnt_q != 2'(QDEPTH));
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_sample_o = mem_q[rd_ptr_q];
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_valid_o & q_ready_i;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage; bits above the sample width are dropped here
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== hw/rtl/mavg_div.sv =====
// ----------------------------------------------------------------------------
// mavg_div: radix-2 restoring divider
// Divides the running sum by the sample count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mavg_div import mavg_pkg::*; #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic [NUM_W-1:0] quotient_o,
  output div_stat_t        stat_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;

  // one restoring step: shift in the next dividend bit, try to subtract
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(NUM_W);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (!diff[DEN_W+1]) begin
        rem_d = diff[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== hw/rtl/mavg_back.sv =====
// ----------------------------------------------------------------------------
// mavg_back: execution side of the moving average block
// Updates the sample ring and running sum, divides by the live count and
// holds the result word until the output stream takes it.
// ----------------------------------------------------------------------------
module mavg_back import mavg_pkg::*; #(
  parameter int WINDOW      = 128,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  output logic                           q_ready_o,
  input  logic [SAMPLE_BITS-1:0]         q_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [SAMPLE_BITS-1:0]         out_avg_o,
  output logic [$clog2(WINDOW+1)-1:0]    out_used_o
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + IDX_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_DIV    = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [IDX_W-1:0]       wr_idx_q, wr_idx_d;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] samp_q;
  logic [SAMPLE_BITS-1:0] old_q;
  logic [SAMPLE_BITS-1:0] ring [WINDOW];
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_avg_q;
  logic [CNT_W-1:0]       out_used_q;
  logic                   full, out_free, load_out, div_start;
  logic [SUM_W-1:0]       quotient;
  div_stat_t              div_stat;

  assign full      = (fill_q == CNT_W'(WINDOW));
  assign out_free  = !out_valid_q || out_ready_i;
  assign q_ready_o = (state_q == ST_IDLE);
  assign div_start = (state_q == ST_UPDATE);
  assign load_out  = (state_q == ST_DIV) && div_stat.done && out_free;

  // sequencer and running state
  always_comb begin
    state_d  = state_q;
    wr_idx_d = wr_idx_q;
    fill_d   = fill_q;
    sum_d    = sum_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        // oldest sample leaves only once the ring is full
        sum_d    = sum_q - (full ? SUM_W'(old_q) : '0) + SUM_W'(samp_q);
        fill_d   = full ? fill_q : fill_q + CNT_W'(1);
        wr_idx_d = (wr_idx_q == IDX_W'(WINDOW - 1)) ? '0 : wr_idx_q + IDX_W'(1);
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wr_idx_q <= '0;
      fill_q   <= '0;
      sum_q    <= '0;
    end else begin
      state_q  <= state_d;
      wr_idx_q <= wr_idx_d;
      fill_q   <= fill_d;
      sum_q    <= sum_d;
    end
  end

  // captured word and sample ring, read data registered
  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) begin
      samp_q <= q_sample_i;
    end
    if (state_q == ST_READ) begin
      old_q <= ring[wr_idx_q];
    end
    if (state_q == ST_UPDATE) begin
      ring[wr_idx_q] <= samp_q;
    end
  end

  mavg_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (fill_d),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_avg_q  <= quotient[SAMPLE_BITS-1:0];
      out_used_q <= fill_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_avg_o   = out_avg_q;
  assign out_used_o  = out_used_q;

  // checks
  a_fill_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> (CNT_W'(wr_idx_q) == fill_q))
    else $error("write index out of step with fill count while filling");

  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> !div_stat.busy)
    else $error("divider started while still busy");

  a_div_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |=> (state_q == ST_DIV) && div_stat.busy)
    else $error("divider did not start after update");

  a_used : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && (out_used_q == fill_q))
    else $error("result word count differs from fill count");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for moving_average_window
// Drives sample words with random gaps, stalls the result channel at random
// and checks every result word against a behavioural boxcar model kept in
// step with the words accepted on the input channel.
// ----------------------------------------------------------------------------
module tb;

  localparam int WINDOW      = 128;
  localparam int SAMPLE_BITS = 10;
  localparam int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W       = ((SAMPLE_BITS + $clog2(WINDOW + 1) + 7) / 8) * 8;
  localparam int WORD_CYCLES = 22;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0]             samples_used;
    logic [SAMPLE_BITS-1:0] average;
  } mean_result_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // tdata: sample
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // tdata: average, samples_used
  logic [OUT_W-1:0] m_axis_tdata;

  // Boxcar model state
  logic [SAMPLE_BITS-1:0] window_ring [WINDOW];
  logic [16:0]            window_sum  = '0;
  logic [6:0]             slot_idx    = '0;
  logic [7:0]             live_count  = '0;

  mean_result_t pending_means [$];
  int           err_count   = 0;
  int           cycle_count = 0;
  bit           tx_idle_en  = 1'b1;
  bit           rx_idle_en  = 1'b1;
  bit           hold_off_req = 1'b0;

  moving_average_window #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Advance the model by one sample and return the mean it yields
  function automatic mean_result_t average_after(logic [SAMPLE_BITS-1:0] smp);
    mean_result_t r;
    if (live_count == 8'(WINDOW)) begin
      window_sum = window_sum - 17'(window_ring[slot_idx]);
    end else begin
      live_count = live_count + 8'd1;
    end
    window_ring[slot_idx] = smp;
    window_sum            = window_sum + 17'(smp);
    slot_idx              = slot_idx + 7'd1;
    r.average      = SAMPLE_BITS'(window_sum / 17'(live_count));
    r.samples_used = live_count;
    return r;
  endfunction

  // Offer one sample word; the model is advanced when it is taken
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(smp);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_means.push_back(average_after(smp));
  endtask

  // Stop offering and wait until every expected result has come
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_means.size() != 0);
    @(posedge clk_i);
  endtask

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      stall = rx_idle_en ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    mean_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = mean_result_t'(m_axis_tdata[$bits(mean_result_t)-1:0]);
      if (pending_means.size() == 0) begin
        $error("unexpected result word: average %0d samples_used %0d",
               got.average, got.samples_used);
        err_count++;
      end else begin
        want = pending_means.pop_front();
        if (got.average !== want.average) begin
          $error("average: expected %0d, got %0d", want.average, got.average);
          err_count++;
        end
        if (got.samples_used !== want.samples_used) begin
          $error("samples_used: expected %0d, got %0d",
                 want.samples_used, got.samples_used);
          err_count++;
        end
      end
    end
  end

  // Extremes, alternating bit patterns and the first steps of the filling phase
  task automatic test_directed();
    logic [SAMPLE_BITS-1:0] vals [20];
    vals = '{10'd0, 10'd1023, 10'd1023, 10'd0, 10'd512, 10'd1, 10'h2AA, 10'h155,
             10'd1022, 10'd2, 10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd3,
             10'd511, 10'd513, 10'd7, 10'd1000};
    foreach (vals[i]) send_sample(vals[i]);
    drain_results();
  endtask

  // Full-scale window, then back to zero: widest sum and the index wrap
  task automatic test_saturated_window();
    repeat (WINDOW + 10) send_sample(10'd1023);
    repeat (WINDOW + 10) send_sample(10'd0);
    drain_results();
  endtask

  // Random blocks with varied content and idling
  task automatic test_random_stream(input int n_blocks);
    int                     style;
    logic [SAMPLE_BITS-1:0] level;
    logic [SAMPLE_BITS-1:0] smp;
    for (int b = 0; b < n_blocks; b++) begin
      style      = $urandom_range(0, 3);
      level      = SAMPLE_BITS'($urandom_range(0, 1023));
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 50; k++) begin
        unique case (style)
          0: smp = SAMPLE_BITS'($urandom_range(0, 1023));
          1: smp = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
          2: smp = level ^ 10'($urandom_range(0, 7));
          default: smp = (k < 25) ? level : ~level;
        endcase
        send_sample(smp);
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    drain_results();
  endtask

  // Receiver holds off while samples keep coming, so the input stalls
  task automatic test_output_backpressure();
    tx_idle_en   = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) send_sample(SAMPLE_BITS'($urandom_range(0, 1023)));
    tx_idle_en = 1'b1;
    drain_results();
  endtask

  // Sender pauses until the block has emptied, then resumes
  task automatic test_sender_pause();
    repeat (3) begin
      repeat (15) send_sample(SAMPLE_BITS'($urandom_range(0, 1023)));
      drain_results();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_saturated_window();
    test_random_stream(20);
    test_output_backpressure();
    test_sender_pause();

    drain_results();
    repeat (4 * WORD_CYCLES) @(posedge clk_i);
    if (pending_means.size() != 0) begin
      $error("%0d results never arrived", pending_means.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mavg_pkg.sv
hw/rtl/mavg_front.sv
hw/rtl/mavg_div.sv
hw/rtl/mavg_back.sv
hw/rtl/moving_average_window.sv
tb/tb.sv
